/* rtl/tes_pkg.sv */
`default_nettype none
package tes_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int CFG_AW = 3;

  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_REMOVE   = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  localparam logic [2:0] KIND_REGISTERED    = 3'd0;
  localparam logic [2:0] KIND_FIRED         = 3'd1;
  localparam logic [2:0] KIND_REMOVED       = 3'd2;
  localparam logic [2:0] KIND_REMOVE_FAIL   = 3'd3;
  localparam logic [2:0] KIND_REGISTER_FAIL = 3'd4;

  localparam logic [CFG_AW-1:0] ADDR_EARLY_WINDOW = 3'd0;
  localparam logic [15:0] EARLY_WINDOW_RESET = 16'd1000;
endpackage
`default_nettype wire

/* rtl/tes_req_if.sv */
`default_nettype none
interface tes_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [47:0] delay_us;
  logic        repeat_req;
  logic [31:0] timer_id;
  modport source (output valid, req_type, delay_us, repeat_req, timer_id, input ready);
  modport sink (input valid, req_type, delay_us, repeat_req, timer_id, output ready);
endinterface
`default_nettype wire

/* rtl/tes_res_if.sv */
`default_nettype none
interface tes_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [31:0] event_id;
  logic        last;
  modport source (output valid, result_kind, event_id, last, input ready);
  modport sink (input valid, result_kind, event_id, last, output ready);
endinterface
`default_nettype wire

/* rtl/tes_ram.sv */
`default_nettype none
module tes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/timer_event_scheduler.sv */
`default_nettype none
// Timer event scheduler: deadline-ordered queue of one-shot and repeating events.
// in_chan (valid/ready) carries requests: register, remove, or a one microsecond
// tick. out_chan (valid/ready) returns results; last marks the final result of a
// request. A tick with nothing due returns nothing. early_window is written over
// the APB port at byte address 0 and read back there.
// One request is handled at a time; in_chan.ready is high only while idle.
// Every search walks the queue once through the slot RAMs, one slot per cycle,
// then evaluates. A register or remove request has its result after one such
// pass; an immediate-fire register skips the search and returns its fired
// result, then its registered result. A tick takes one pass per fired event plus
// one final pass, unless the fire limit of MAX_RESULTS ends it first.
// Results go out through one output register; while the receiver stalls the
// sequencer waits with the next result held.
// Reset (rst_n low, synchronous) empties the queue, clears time, sets the next
// id to 1 and the window to 1000.
module timer_event_scheduler #(
  parameter int QUEUE_DEPTH = tes_pkg::QUEUE_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  tes_req_if.sink                        in_chan,
  tes_res_if.source                      out_chan,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [tes_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready
);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int INFO_W = 1 + 48 + 32;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SCAN_END, S_EVAL, S_EMIT, S_IMM, S_TNEXT
  } state_t;

  state_t state_r, ret_r;
  logic [QUEUE_DEPTH-1:0] valid_r, seen_r;
  logic [63:0] now_r, limit_r;
  logic [31:0] next_id_r;
  logic [15:0] window_r;

  logic [1:0]  req_r;
  logic [47:0] delay_r;
  logic        rep_r;
  logic [31:0] tid_r;

  logic [IW-1:0] scan_idx_r, pend_idx_r, best_idx_r;
  logic          pend_r, found_r;
  logic [63:0]   best_dl_r;
  logic [31:0]   best_id_r;
  logic          best_rep_r;
  logic [47:0]   best_per_r;
  logic [tes_pkg::CNT_W-1:0] cnt_r;
  logic          have_pend_r;
  logic [31:0]   pend_id_r;

  logic [2:0]  res_kind_r;
  logic [31:0] res_id_r;
  logic        res_last_r;
  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [31:0] out_id_r;
  logic        out_last_r;

  logic          dl_we, info_we;
  logic [IW-1:0] dl_waddr;
  logic [63:0]   dl_wdata, rd_dl;
  logic [INFO_W-1:0] info_wdata, rd_info;
  logic [31:0]   rd_id, id_inc;
  logic          hit, tick_ok;
  logic [63:0]   q_deadline, rq_deadline;

  assign rd_id = rd_info[31:0];
  assign id_inc = (next_id_r + 32'd1 == 32'd0) ? 32'd1 : next_id_r + 32'd1;
  assign q_deadline = now_r + {16'd0, delay_r};
  assign rq_deadline = now_r + {16'd0, best_per_r};

  always_comb begin
    hit = 1'b0;
    unique case (req_r)
      tes_pkg::REQ_REGISTER: hit = !valid_r[pend_idx_r] && !found_r;
      tes_pkg::REQ_REMOVE:   hit = valid_r[pend_idx_r] && !found_r && tid_r != 32'd0
                                   && rd_id == tid_r;
      default:               hit = valid_r[pend_idx_r] && !seen_r[pend_idx_r]
                                   && (!found_r || rd_dl < best_dl_r);
    endcase
  end

  assign tick_ok = found_r && best_dl_r <= limit_r && (cnt_r != '0 || best_dl_r <= now_r);

  always_comb begin
    dl_we = 1'b0;
    info_we = 1'b0;
    dl_waddr = best_idx_r;
    dl_wdata = q_deadline;
    info_wdata = {rep_r, delay_r, next_id_r};
    if (state_r == S_EVAL) begin
      if (req_r == tes_pkg::REQ_REGISTER && found_r) begin
        dl_we = 1'b1;
        info_we = 1'b1;
      end else if (req_r == tes_pkg::REQ_TICK && tick_ok && best_rep_r) begin
        dl_we = 1'b1;
        dl_wdata = rq_deadline;
      end
    end
  end

  tes_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_dl_ram (
    .clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
    .raddr(scan_idx_r), .rdata(rd_dl)
  );

  tes_ram #(.WIDTH(INFO_W), .DEPTH(QUEUE_DEPTH)) u_info_ram (
    .clk(clk), .we(info_we), .waddr(dl_waddr), .wdata(info_wdata),
    .raddr(scan_idx_r), .rdata(rd_info)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.event_id = out_id_r;
  assign out_chan.last = out_last_r;
  assign pready = 1'b1;
  assign prdata = (paddr == tes_pkg::ADDR_EARLY_WINDOW) ? {16'd0, window_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      valid_r <= '0;
      seen_r <= '0;
      now_r <= 64'd0;
      next_id_r <= 32'd1;
      window_r <= tes_pkg::EARLY_WINDOW_RESET;
      out_valid_r <= 1'b0;
      pend_r <= 1'b0;
      found_r <= 1'b0;
      have_pend_r <= 1'b0;
      cnt_r <= '0;
      scan_idx_r <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == tes_pkg::ADDR_EARLY_WINDOW) begin
        window_r <= pwdata[15:0];
      end
      if (out_chan.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_SCAN || state_r == S_SCAN_END) && pend_r && hit) begin
        found_r <= 1'b1;
        best_idx_r <= pend_idx_r;
        best_dl_r <= rd_dl;
        best_id_r <= rd_id;
        best_rep_r <= rd_info[INFO_W-1];
        best_per_r <= rd_info[79:32];
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            req_r <= in_chan.req_type;
            delay_r <= in_chan.delay_us;
            rep_r <= in_chan.repeat_req;
            tid_r <= in_chan.timer_id;
            scan_idx_r <= '0;
            pend_r <= 1'b0;
            found_r <= 1'b0;
            unique case (in_chan.req_type)
              tes_pkg::REQ_REGISTER: begin
                if (in_chan.delay_us < {32'd0, window_r}) begin
                  res_kind_r <= tes_pkg::KIND_FIRED;
                  res_id_r <= next_id_r;
                  res_last_r <= 1'b0;
                  pend_id_r <= next_id_r;
                  next_id_r <= id_inc;
                  ret_r <= S_IMM;
                  state_r <= S_EMIT;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              tes_pkg::REQ_REMOVE: state_r <= S_SCAN;
              tes_pkg::REQ_TICK: begin
                now_r <= now_r + 64'd1;
                seen_r <= '0;
                cnt_r <= '0;
                have_pend_r <= 1'b0;
                state_r <= S_SCAN;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          limit_r <= now_r + {48'd0, window_r};
          pend_r <= 1'b1;
          pend_idx_r <= scan_idx_r;
          scan_idx_r <= scan_idx_r + IW'(1);
          if (scan_idx_r == IW'(QUEUE_DEPTH - 1)) begin
            state_r <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          pend_r <= 1'b0;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          unique case (req_r)
            tes_pkg::REQ_REGISTER: begin
              res_last_r <= 1'b1;
              ret_r <= S_IDLE;
              state_r <= S_EMIT;
              if (found_r) begin
                valid_r[best_idx_r] <= 1'b1;
                res_kind_r <= tes_pkg::KIND_REGISTERED;
                res_id_r <= next_id_r;
                next_id_r <= id_inc;
              end else begin
                res_kind_r <= tes_pkg::KIND_REGISTER_FAIL;
                res_id_r <= 32'd0;
              end
            end
            tes_pkg::REQ_REMOVE: begin
              res_last_r <= 1'b1;
              ret_r <= S_IDLE;
              state_r <= S_EMIT;
              if (found_r) begin
                valid_r[best_idx_r] <= 1'b0;
                res_kind_r <= tes_pkg::KIND_REMOVED;
                res_id_r <= tid_r;
              end else begin
                res_kind_r <= tes_pkg::KIND_REMOVE_FAIL;
                res_id_r <= 32'd0;
              end
            end
            default: begin
              if (tick_ok) begin
                seen_r[best_idx_r] <= 1'b1;
                if (!best_rep_r) begin
                  valid_r[best_idx_r] <= 1'b0;
                end
                cnt_r <= cnt_r + tes_pkg::CNT_W'(1);
                have_pend_r <= 1'b1;
                pend_id_r <= best_id_r;
                if (have_pend_r) begin
                  res_kind_r <= tes_pkg::KIND_FIRED;
                  res_id_r <= pend_id_r;
                  res_last_r <= 1'b0;
                  ret_r <= S_TNEXT;
                  state_r <= S_EMIT;
                end else begin
                  state_r <= S_TNEXT;
                end
              end else if (have_pend_r) begin
                res_kind_r <= tes_pkg::KIND_FIRED;
                res_id_r <= pend_id_r;
                res_last_r <= 1'b1;
                ret_r <= S_IDLE;
                state_r <= S_EMIT;
              end else begin
                state_r <= S_IDLE;
              end
            end
          endcase
        end
        S_TNEXT: begin
          if (cnt_r == tes_pkg::CNT_W'(tes_pkg::MAX_RESULTS)) begin
            res_kind_r <= tes_pkg::KIND_FIRED;
            res_id_r <= pend_id_r;
            res_last_r <= 1'b1;
            ret_r <= S_IDLE;
            state_r <= S_EMIT;
          end else begin
            scan_idx_r <= '0;
            pend_r <= 1'b0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_IMM: begin
          res_kind_r <= tes_pkg::KIND_REGISTERED;
          res_id_r <= pend_id_r;
          res_last_r <= 1'b1;
          ret_r <= S_IDLE;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_kind_r <= res_kind_r;
            out_id_r <= res_id_r;
            out_last_r <= res_last_r;
            state_r <= ret_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
